// ===== src/datetime_add_minutes_defines.svh =====
// ----------------------------------------------------------------------------
// datetime_add_minutes_defines.svh
// Assertion macros shared by the date and time adder modules.
// ----------------------------------------------------------------------------
`ifndef DATETIME_ADD_MINUTES_DEFINES_SVH
`define DATETIME_ADD_MINUTES_DEFINES_SVH

`ifndef SYNTH
// Check that a condition holds in the same cycle as its trigger
`define DAM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dam: same-cycle check failed");
// Check that a condition holds in the cycle after its trigger
`define DAM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dam: next-cycle check failed");
`else
`define DAM_ASSERT_IMP(lbl, ante, cons)
`define DAM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== src/dam_pkg.sv =====
// ----------------------------------------------------------------------------
// dam_pkg
// Types, constants and the month length function of the date and time adder.
// ----------------------------------------------------------------------------
`default_nettype none

package dam_pkg;

	// Field widths
	localparam int ADD_WIDTH = 20;
	localparam int YEAR_W    = 16;
	localparam int MONTH_W   = 4;
	localparam int DAY_W     = 5;
	localparam int HOUR_W    = 5;
	localparam int MIN_W     = 6;

	localparam int MIN_PER_HOUR  = 60;
	localparam int HOUR_PER_DAY  = 24;
	localparam int MONTHS        = 12;

	// Total minutes, carried hours and carried days widths
	localparam int TW = ADD_WIDTH + 1;
	localparam int HW = TW - 3;
	localparam int DW = (HW - 2 > 6) ? HW - 2 : 6;

	// Reciprocal multipliers: the rounded-up reciprocal is exact over the
	// whole operand range, as the rounding error times the operand stays
	// below two to the power of the shift.
	localparam int K60   = TW + 6;
	localparam int Q60W  = TW - 5;
	localparam logic [TW:0] M60 = (TW + 1)'(((64'd1 << K60) / 60) + 1);

	localparam int K24   = HW + 5;
	localparam int Q24W  = HW - 4;
	localparam logic [HW:0] M24 = (HW + 1)'(((64'd1 << K24) / 24) + 1);

	localparam int K25   = YEAR_W + 5;
	localparam int Q25W  = 12;
	localparam logic [YEAR_W:0] M25 = (YEAR_W + 1)'(((64'd1 << K25) / 25) + 1);

	// Year residue modulo 25 at the top of the year range
	localparam logic [4:0] YEAR_TOP_MOD25 = 5'(65535 % 25);

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_MUL60,
		OP_DIV60,
		OP_MUL24,
		OP_DIV24,
		OP_ROLL,
		OP_BACK,
		OP_SETDAY
	} op_t;

	typedef struct packed {
		op_t  op;
		logic store;
	} cmd_t;

	typedef struct packed {
		logic more;
		logic zero;
	} status_t;

	// Days in a month, given whether the year is a leap year
	function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] mon,
		input logic leap);
		logic [DAY_W-1:0] d;
		unique case (mon)
			4'd2:                      d = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
			default:                   d = 5'd31;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

// ===== src/dam_ctrl.sv =====
// ----------------------------------------------------------------------------
// dam_ctrl
// Sequencer of the date and time adder: steps the datapath through the
// divisions and the month roll, and owns both stream handshakes.
// ----------------------------------------------------------------------------
`default_nettype none
`include "datetime_add_minutes_defines.svh"

module dam_ctrl import dam_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    s_tvalid,
	output logic         s_tready,
	output logic         m_tvalid,
	input  wire logic    m_tready,
	input  wire status_t status,
	output cmd_t         cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL60,
		ST_DIV60,
		ST_MUL24,
		ST_DIV24,
		ST_ROLL,
		ST_BACK,
		ST_SETDAY,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   m_tvalid_q;
	logic   out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

	// Decode the datapath command from the state
	always_comb begin
		cmd.store = 1'b0;
		unique case (state_q)
			ST_IDLE:   cmd.op = s_tvalid ? OP_LOAD : OP_NONE;
			ST_MUL60:  cmd.op = OP_MUL60;
			ST_DIV60:  cmd.op = OP_DIV60;
			ST_MUL24:  cmd.op = OP_MUL24;
			ST_DIV24:  cmd.op = OP_DIV24;
			ST_ROLL:   cmd.op = OP_ROLL;
			ST_BACK:   cmd.op = OP_BACK;
			ST_SETDAY: cmd.op = OP_SETDAY;
			ST_DONE: begin
				cmd.op    = OP_NONE;
				cmd.store = out_free;
			end
			default:   cmd.op = OP_NONE;
		endcase
	end

	// Advance the sequence and hold the result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE:   if (s_tvalid) state_q <= ST_MUL60;
				ST_MUL60:  state_q <= ST_DIV60;
				ST_DIV60:  state_q <= ST_MUL24;
				ST_MUL24:  state_q <= ST_DIV24;
				ST_DIV24:  state_q <= ST_ROLL;
				ST_ROLL: begin
					if (!status.more) state_q <= status.zero ? ST_BACK : ST_DONE;
				end
				ST_BACK:   state_q <= ST_SETDAY;
				ST_SETDAY: state_q <= ST_DONE;
				ST_DONE:   if (out_free) state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
			if (cmd.store) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	`DAM_ASSERT_NEXT(a_request_starts_work, s_tvalid && s_tready, state_q == ST_MUL60)
	`DAM_ASSERT_IMP(a_store_only_when_free, cmd.store, !m_tvalid_q || m_tready)
	`DAM_ASSERT_NEXT(a_store_raises_valid, cmd.store, m_tvalid_q && state_q == ST_IDLE)

endmodule

`default_nettype wire

// ===== src/dam_datapath.sv =====
// ----------------------------------------------------------------------------
// dam_datapath
// Working registers of the date and time adder: reciprocal divisions by 60
// and 24, year residue modulo 25 for the leap rule, month roll and result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "datetime_add_minutes_defines.svh"

module dam_datapath import dam_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cmd_t                 cmd,
	output status_t                   status,
	input  wire logic [YEAR_W-1:0]    start_year,
	input  wire logic [MONTH_W-1:0]   start_month,
	input  wire logic [DAY_W-1:0]     start_day,
	input  wire logic [HOUR_W-1:0]    start_hour,
	input  wire logic [MIN_W-1:0]     start_minute,
	input  wire logic [ADD_WIDTH-1:0] minutes_to_add,
	output logic [YEAR_W-1:0]         end_year,
	output logic [MONTH_W-1:0]        end_month,
	output logic [DAY_W-1:0]          end_day,
	output logic [HOUR_W-1:0]         end_hour,
	output logic [MIN_W-1:0]          end_minute,
	output logic                      year_overflow
);

	logic [TW-1:0]       t_q;
	logic [HW-1:0]       hsum_q;
	logic [DW-1:0]       day_q;
	logic [YEAR_W-1:0]   year_q;
	logic [MONTH_W-1:0]  mon_q;
	logic [HOUR_W-1:0]   hr_q;
	logic [MIN_W-1:0]    min_q;
	logic [4:0]          mod25_q;
	logic                ovf_q;
	logic [2*TW:0]       prod60_q;
	logic [2*HW:0]       prod24_q;
	logic [2*YEAR_W:0]   prod25_q;

	logic [Q60W-1:0]     q60;
	logic [TW-1:0]       rem60;
	logic [Q24W-1:0]     q24;
	logic [HW-1:0]       rem24;
	logic [Q25W-1:0]     q25;
	logic [YEAR_W-1:0]   rem25;
	logic                leap;
	logic [DAY_W-1:0]    dim;
	logic [DW-1:0]       dim_ext;
	logic                mon_bad;
	logic [4:0]          mod25_inc;
	logic [4:0]          mod25_dec;

	// Take the quotients from the reciprocal products
	assign q60   = prod60_q[K60 +: Q60W];
	assign rem60 = t_q - TW'(q60) * TW'(MIN_PER_HOUR);
	assign q24   = prod24_q[K24 +: Q24W];
	assign rem24 = hsum_q - HW'(q24) * HW'(HOUR_PER_DAY);
	assign q25   = prod25_q[K25 +: Q25W];
	assign rem25 = year_q - YEAR_W'(q25) * YEAR_W'(25);

	// Leap year: divisible by 4, and either not by 25 or also by 16
	assign leap    = (year_q[1:0] == 2'd0) && ((mod25_q != 5'd0) || (year_q[3:0] == 4'd0));
	assign dim     = days_in_month(mon_q, leap);
	assign dim_ext = DW'(dim);

	assign status.more = (day_q > dim_ext);
	assign status.zero = (day_q == '0);

	assign mon_bad   = (start_month == '0) || (start_month > MONTH_W'(MONTHS));
	assign mod25_inc = (year_q == '1) ? 5'd0 :
		((mod25_q == 5'd24) ? 5'd0 : mod25_q + 5'd1);
	assign mod25_dec = (year_q == '0) ? YEAR_TOP_MOD25 :
		((mod25_q == 5'd0) ? 5'd24 : mod25_q - 5'd1);

	// Step the working registers as commanded
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				t_q    <= TW'(start_minute) + TW'(minutes_to_add);
				year_q <= start_year;
				mon_q  <= mon_bad ? MONTH_W'(1) : start_month;
				day_q  <= DW'(start_day);
				hr_q   <= start_hour;
				ovf_q  <= 1'b0;
			end
			OP_MUL60: begin
				prod60_q <= (2*TW+1)'(t_q) * (2*TW+1)'(M60);
				prod25_q <= (2*YEAR_W+1)'(year_q) * (2*YEAR_W+1)'(M25);
			end
			OP_DIV60: begin
				min_q   <= rem60[MIN_W-1:0];
				hsum_q  <= HW'(hr_q) + HW'(q60);
				mod25_q <= rem25[4:0];
			end
			OP_MUL24: begin
				prod24_q <= (2*HW+1)'(hsum_q) * (2*HW+1)'(M24);
			end
			OP_DIV24: begin
				hr_q  <= rem24[HOUR_W-1:0];
				day_q <= day_q + DW'(q24);
			end
			OP_ROLL: begin
				// Drop a whole month while the days exceed its length
				if (status.more) begin
					day_q <= day_q - dim_ext;
					if (mon_q == MONTH_W'(MONTHS)) begin
						mon_q   <= MONTH_W'(1);
						year_q  <= year_q + YEAR_W'(1);
						mod25_q <= mod25_inc;
						if (year_q == '1) ovf_q <= 1'b1;
					end else begin
						mon_q <= mon_q + MONTH_W'(1);
					end
				end
			end
			OP_BACK: begin
				// Day zero: step back to the previous month
				if (mon_q == MONTH_W'(1)) begin
					mon_q   <= MONTH_W'(MONTHS);
					year_q  <= year_q - YEAR_W'(1);
					mod25_q <= mod25_dec;
					if (year_q == '0) ovf_q <= 1'b1;
				end else begin
					mon_q <= mon_q - MONTH_W'(1);
				end
			end
			OP_SETDAY: begin
				day_q <= dim_ext;
			end
			default: begin
			end
		endcase
		// Capture the finished result
		if (cmd.store) begin
			end_year      <= year_q;
			end_month     <= mon_q;
			end_day       <= day_q[DAY_W-1:0];
			end_hour      <= hr_q;
			end_minute    <= min_q;
			year_overflow <= ovf_q;
		end
	end

	`DAM_ASSERT_IMP(a_roll_month_in_range, cmd.op == OP_ROLL, mon_q >= 4'd1 && mon_q <= 4'd12)
	`DAM_ASSERT_IMP(a_roll_time_in_range, cmd.op == OP_ROLL, hr_q < 5'd24 && min_q < 6'd60)
	`DAM_ASSERT_IMP(a_residue_in_range, cmd.op == OP_ROLL, mod25_q < 5'd25)

endmodule

`default_nettype wire

// ===== src/datetime_add_minutes.sv =====
// ----------------------------------------------------------------------------
// datetime_add_minutes
// Adds a count of minutes to a Gregorian date and time and gives the
// normalised date and time, with a flag when the year wraps.
// ----------------------------------------------------------------------------
// Sequence: once a request is taken, the block multiplies and divides by 60, then by 24,
// rolls month by month while the days exceed the month length, steps back to the previous
// month when the day ends at zero, and stores the result. One request is in work at a time.
// The result register lets the next request enter while a result waits.
// Reset clears the sequencer and the result valid flag; data is not reset.
`default_nettype none

module datetime_add_minutes import dam_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// start_year, start_month, start_day, start_hour, start_minute, minutes_to_add
	input  wire logic [55:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// end_year, end_month, end_day, end_hour, end_minute, year_overflow, zero fill
	output logic [39:0]      m_tdata
);

	cmd_t               cmd;
	status_t            status;
	logic [YEAR_W-1:0]  end_year;
	logic [MONTH_W-1:0] end_month;
	logic [DAY_W-1:0]   end_day;
	logic [HOUR_W-1:0]  end_hour;
	logic [MIN_W-1:0]   end_minute;
	logic               year_overflow;

	dam_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	dam_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.start_year     (s_tdata[15:0]),
		.start_month    (s_tdata[19:16]),
		.start_day      (s_tdata[24:20]),
		.start_hour     (s_tdata[29:25]),
		.start_minute   (s_tdata[35:30]),
		.minutes_to_add (s_tdata[55:36]),
		.end_year       (end_year),
		.end_month      (end_month),
		.end_day        (end_day),
		.end_hour       (end_hour),
		.end_minute     (end_minute),
		.year_overflow  (year_overflow)
	);

	// Pack the result fields, lowest first
	assign m_tdata = {3'b000, year_overflow, end_minute, end_hour, end_day, end_month,
		end_year};

endmodule

`default_nettype wire
